### src/srpf_pkg.sv
// Shared constants for the source-route packet forwarder.
// Field widths, action codes and configuration register indexes.
// No dependencies.
package srpf_pkg;

  localparam int NUM_PORTS      = 4;
  localparam int MAX_PACKET_LEN = 64;

  localparam int ADDR_W  = $clog2(MAX_PACKET_LEN);
  localparam int LEN_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int MASK_W  = 4;
  localparam int ACT_W   = 2;
  localparam int PORT_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_LOCAL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FLOOD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PORT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DROP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd3;

  localparam logic [BYTE_W-1:0] LOCAL_CODE_RST = 8'd254;
  localparam logic [BYTE_W-1:0] FLOOD_CODE_RST = 8'd253;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'd255;

endpackage

### src/source_route_packet_forwarder_unit.sv
// Source-route packet forwarder: frames length-prefixed packets into a
// packet buffer, rewrites the route header in place and emits the packet.
// Depends on srpf_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_rx_byte           | receive
//  out     | out_valid, out_ready, out_byte, out_index,| transmit
//          | out_route_action, out_dest_mask, out_last |
//  cfg     | cfg_wr_en, cfg_index, cfg_data           | write only
//
// Receive takes one byte per cycle. After the last byte of an N-byte packet
// whose delimiter sits at index k, the rewrite reads each of the k - 1 route
// bytes (at most N - 2) and writes it one place down, the route lookup reads
// and checks byte 1, and the emission reads and loads each byte in turn; all
// steps use the packet buffer, whose read data is registered. Dropped short
// or oversize packets give their result straight from receive. Receive is
// closed while a packet is rewritten or emitted, and a stalled output holds
// the sequencer. In receive, a byte that would complete a packet waits while
// the output register is full. Reset is synchronous; the buffer is not cleared.
module source_route_packet_forwarder_unit
  import srpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [INDEX_W-1:0]   out_index,
  output logic [ACT_W-1:0]     out_route_action,
  output logic [MASK_W-1:0]    out_dest_mask,
  output logic                 out_last,

  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_RX,
    S_REW_RD,
    S_REW_CHK,
    S_ROUTE_RD,
    S_ROUTE_CHK,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r;

  logic [PORT_W-1:0] own_port_r;
  logic [BYTE_W-1:0] local_code_r;
  logic [BYTE_W-1:0] flood_code_r;
  logic [BYTE_W-1:0] end_code_r;

  logic [LEN_W-1:0]  pos_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  idx_r;
  logic [ACT_W-1:0]  act_r;
  logic [MASK_W-1:0] mask_r;

  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [INDEX_W-1:0]   out_index_r;
  logic [ACT_W-1:0]     out_act_r;
  logic [MASK_W-1:0]    out_mask_r;
  logic                 out_last_r;

  // packet buffer
  logic [BYTE_W-1:0] mem [MAX_PACKET_LEN];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_q_r;

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  pos_inc;
  logic              completes;
  logic              len_bad;
  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic [LEN_W-1:0]  idx_inc;
  logic              is_delim;
  logic [MASK_W-1:0] flood_mask;
  logic [MASK_W-1:0] port_mask;

  assign len_eff   = (pos_r == '0) ? in_rx_byte : len_r;
  assign pos_inc   = pos_r + LEN_W'(1);
  assign completes = (pos_inc >= len_eff);
  assign len_bad   = (len_eff < LEN_W'(2)) || (len_eff > LEN_W'(MAX_PACKET_LEN));
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_RX) && (out_free || !completes);
  assign in_fire   = in_valid && in_ready;
  assign idx_inc   = idx_r + LEN_W'(1);
  assign is_delim  = (mem_q_r == end_code_r);
  // output register takes a new transaction this cycle
  assign out_load  = (in_fire && completes && len_bad) ||
                     ((state_r == S_EMIT_LD) && out_free);

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      flood_mask[i] = (i < NUM_PORTS) && (PORT_W'(i) != own_port_r);
      port_mask[i]  = (mem_q_r == BYTE_W'(i));
    end
  end

  // buffer port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r[ADDR_W-1:0];
    mem_wdata = in_rx_byte;
    mem_re    = 1'b0;
    mem_raddr = idx_r[ADDR_W-1:0];
    unique case (state_r)
      S_RX: begin
        mem_we = in_fire && (pos_r < LEN_W'(MAX_PACKET_LEN));
      end
      S_REW_RD, S_EMIT_RD: begin
        mem_re = 1'b1;
      end
      S_REW_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(idx_r - LEN_W'(1));
        mem_wdata = is_delim ? BYTE_W'(own_port_r) : mem_q_r;
      end
      S_ROUTE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(1);
      end
      S_ROUTE_CHK, S_EMIT_LD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_port_r   <= '0;
      local_code_r <= LOCAL_CODE_RST;
      flood_code_r <= FLOOD_CODE_RST;
      end_code_r   <= END_CODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OWN_PORT:   own_port_r   <= cfg_data[PORT_W-1:0];
        CFG_LOCAL_CODE: local_code_r <= cfg_data;
        CFG_FLOOD_CODE: flood_code_r <= cfg_data;
        CFG_END_CODE:   end_code_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      pos_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_RX: begin
          if (in_fire) begin
            if (pos_r == '0) begin
              len_r <= in_rx_byte;
            end
            if (!completes) begin
              pos_r <= pos_inc;
            end else begin
              pos_r <= '0;
              if (len_bad) begin
                // short or oversize: one drop transaction with the length byte
                out_byte_r  <= len_eff;
                out_index_r <= '0;
                out_act_r   <= ACT_DROP;
                out_mask_r  <= '0;
                out_last_r  <= 1'b1;
              end else if (len_eff == LEN_W'(2)) begin
                state_r <= S_ROUTE_RD;
              end else begin
                idx_r   <= LEN_W'(2);
                state_r <= S_REW_RD;
              end
            end
          end
        end
        S_REW_RD: begin
          state_r <= S_REW_CHK;
        end
        S_REW_CHK: begin
          // shift one route byte down; at the delimiter write the own port below it and end the header
          if (is_delim || (idx_inc >= len_r)) begin
            state_r <= S_ROUTE_RD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_REW_RD;
          end
        end
        S_ROUTE_RD: begin
          state_r <= S_ROUTE_CHK;
        end
        S_ROUTE_CHK: begin
          if (mem_q_r == local_code_r) begin
            act_r  <= ACT_LOCAL;
            mask_r <= '0;
          end else if (mem_q_r == flood_code_r) begin
            act_r  <= ACT_FLOOD;
            mask_r <= flood_mask;
          end else if (mem_q_r >= BYTE_W'(NUM_PORTS)) begin
            act_r  <= ACT_DROP;
            mask_r <= '0;
          end else begin
            act_r  <= ACT_PORT;
            mask_r <= port_mask;
          end
          idx_r   <= '0;
          state_r <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_byte_r  <= mem_q_r;
            out_index_r <= INDEX_W'(idx_r);
            out_act_r   <= act_r;
            out_mask_r  <= mask_r;
            out_last_r  <= (idx_inc == len_r);
            if (idx_inc == len_r) begin
              state_r <= S_RX;
            end else begin
              idx_r   <= idx_inc;
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= S_RX;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_index        = out_index_r;
  assign out_route_action = out_act_r;
  assign out_dest_mask    = out_mask_r;
  assign out_last         = out_last_r;

endmodule
